// ===== rtl/core/tcgr_pkg.sv =====
// Shared types, constants and the fixed palette for the text cell glyph renderer.
package tcgr_pkg;

    localparam int GLYPH_WIDTH  = 4;
    localparam int GLYPH_HEIGHT = 8;
    localparam int FONT_WORDS   = 256;
    localparam int PALETTE_SIZE = 16;
    localparam int PIXELS       = GLYPH_WIDTH * GLYPH_HEIGHT;
    localparam int PIX_CNT_W    = $clog2(PIXELS);

    typedef enum logic [1:0] {
        FUNC_RENDER     = 2'd0,
        FUNC_WR_PALETTE = 2'd1,
        FUNC_WR_DEFAULT = 2'd2,
        FUNC_WR_CUSTOM  = 2'd3
    } func_t;

    typedef enum logic {
        REG_PALETTE_SOURCE = 1'b0,
        REG_FONT_SOURCE    = 1'b1
    } reg_index_t;

    // Everything the pixel serializer needs for one cell.
    typedef struct packed {
        logic [4:0]  col;
        logic [3:0]  row;
        logic [11:0] fg;
        logic [11:0] bg;
        logic [31:0] glyph;
    } render_req_t;

    function automatic logic [11:0] fixed_color(input logic [3:0] idx);
        logic [11:0] c;
        case (idx)
            4'd0:    c = 12'h000;
            4'd1:    c = 12'h00A;
            4'd2:    c = 12'h0A0;
            4'd3:    c = 12'h0AA;
            4'd4:    c = 12'hA00;
            4'd5:    c = 12'hA0A;
            4'd6:    c = 12'hA50;
            4'd7:    c = 12'hAAA;
            4'd8:    c = 12'h555;
            4'd9:    c = 12'h55F;
            4'd10:   c = 12'h5F5;
            4'd11:   c = 12'h5FF;
            4'd12:   c = 12'hF55;
            4'd13:   c = 12'hF5F;
            4'd14:   c = 12'hFF5;
            4'd15:   c = 12'hFFF;
            default: c = 12'h000;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/tcgr_ram.sv =====
// Synchronous RAM, one write port and two registered read ports.
module tcgr_ram #(
    parameter int DEPTH = tcgr_pkg::FONT_WORDS,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

// ===== rtl/core/tcgr_serializer.sv =====
// Pixel serializer: walks one glyph column by column and holds the output register.
module tcgr_serializer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load_valid,
    input  tcgr_pkg::render_req_t req,
    output logic                  load_ready,
    output logic                  pixel_valid,
    input  logic                  pixel_stall,
    output logic [6:0]            pixel_x,
    output logic [6:0]            pixel_y,
    output logic [7:0]            red,
    output logic [7:0]            green,
    output logic [7:0]            blue,
    output logic                  is_foreground,
    output logic                  last
);

    localparam logic [tcgr_pkg::PIX_CNT_W-1:0] LAST_PIX =
        tcgr_pkg::PIX_CNT_W'(tcgr_pkg::PIXELS - 1);

    logic                            busy_reg;
    logic [tcgr_pkg::PIX_CNT_W-1:0]  cnt_reg;
    logic [31:0]                     glyph_reg;
    logic [11:0]                     fg_reg;
    logic [11:0]                     bg_reg;
    logic [4:0]                      col_reg;
    logic [3:0]                      row_reg;
    logic                            out_valid_reg;

    logic        out_ready;
    logic        emit;
    logic        load;
    logic        on;
    logic [11:0] color;

    assign out_ready  = !out_valid_reg || !pixel_stall;
    assign emit       = busy_reg && out_ready;
    assign load_ready = !busy_reg || (emit && (cnt_reg == LAST_PIX));
    assign load       = load_valid && load_ready;
    assign on         = glyph_reg[31];
    assign color      = on ? fg_reg : bg_reg;
    assign pixel_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (emit)
            begin
                if (cnt_reg == LAST_PIX)
                begin
                    busy_reg <= 1'b0;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (out_ready)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            glyph_reg <= req.glyph;
            fg_reg    <= req.fg;
            bg_reg    <= req.bg;
            col_reg   <= req.col;
            row_reg   <= req.row;
        end
        else if (emit)
        begin
            glyph_reg <= {glyph_reg[30:0], 1'b0};
        end
        if (emit)
        begin
            // column in the upper count bits, rows run bottom to top
            pixel_x       <= {col_reg, cnt_reg[4:3]};
            pixel_y       <= {row_reg, ~cnt_reg[2:0]};
            red           <= {color[11:8], color[11:8]};
            green         <= {color[7:4], color[7:4]};
            blue          <= {color[3:0], color[3:0]};
            is_foreground <= on;
            last          <= (cnt_reg == LAST_PIX);
        end
    end

endmodule

// ===== rtl/core/text_cell_glyph_renderer.sv =====
// Top level of the text cell glyph renderer: cell intake, stores, config port.
//
// Each render transfer yields 32 pixel transfers, one per cycle when the pixel side
// does not stall, so a steady stream of cells is paced by the single pixel serializer.
// A cell is taken while the previous one is still being serialized: the font and
// palette RAMs are read at the transfer edge, the data lands in a holding stage and
// moves into the serializer as its last pixel leaves. Store writes produce no pixels.
// Font and palette RAMs have no reset; render only glyphs and custom colors that
// were written first.
module text_cell_glyph_renderer #(
    parameter int FONT_WORDS = tcgr_pkg::FONT_WORDS
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB-style register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // cell side
    input  logic        cell_valid,
    output logic        cell_stall,
    input  logic [1:0]  func,
    input  logic [15:0] cell_word,
    input  logic [4:0]  cell_col,
    input  logic [3:0]  cell_row,
    input  logic        blink_on,
    input  logic [7:0]  write_index,
    input  logic [15:0] write_data,
    // pixel side
    output logic        pixel_valid,
    input  logic        pixel_stall,
    output logic [6:0]  pixel_x,
    output logic [6:0]  pixel_y,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic        is_foreground,
    output logic        last
);

    localparam int FONT_AW = $clog2(FONT_WORDS);
    localparam int PAL_AW  = $clog2(tcgr_pkg::PALETTE_SIZE);

    logic palette_source_reg;
    logic font_source_reg;

    logic       s1_valid_reg;
    logic [4:0] s1_col_reg;
    logic [3:0] s1_row_reg;
    logic       s1_show_reg;
    logic [3:0] s1_fg_idx_reg;
    logic [3:0] s1_bg_idx_reg;

    logic                  accept;
    logic                  render;
    logic                  load_ready;
    logic [FONT_AW-1:0]    font_addr_hi;
    logic [FONT_AW-1:0]    font_addr_lo;
    logic [15:0]           def_hi;
    logic [15:0]           def_lo;
    logic [15:0]           cus_hi;
    logic [15:0]           cus_lo;
    logic [11:0]           pal_fg;
    logic [11:0]           pal_bg;
    logic                  cfg_write;
    tcgr_pkg::render_req_t req;

    // config registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_source_reg <= 1'b0;
            font_source_reg    <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (tcgr_pkg::reg_index_t'(paddr[2]))
                tcgr_pkg::REG_PALETTE_SOURCE: palette_source_reg <= pwdata[0];
                tcgr_pkg::REG_FONT_SOURCE:    font_source_reg    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (tcgr_pkg::reg_index_t'(paddr[2]))
            tcgr_pkg::REG_PALETTE_SOURCE: prdata = {31'd0, palette_source_reg};
            tcgr_pkg::REG_FONT_SOURCE:    prdata = {31'd0, font_source_reg};
            default:                      prdata = 32'd0;
        endcase
    end

    // intake: holding stage is free when empty or handing off to the serializer
    assign cell_stall   = s1_valid_reg && !load_ready;
    assign accept       = cell_valid && !cell_stall;
    assign render       = accept && (tcgr_pkg::func_t'(func) == tcgr_pkg::FUNC_RENDER);
    assign font_addr_hi = FONT_AW'({cell_word[6:0], 1'b0});
    assign font_addr_lo = FONT_AW'({cell_word[6:0], 1'b1});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (render)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (load_ready)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (render)
        begin
            s1_col_reg    <= cell_col;
            s1_row_reg    <= cell_row;
            s1_show_reg   <= !cell_word[7] || blink_on;
            s1_fg_idx_reg <= cell_word[15:12];
            s1_bg_idx_reg <= cell_word[11:8];
        end
    end

    tcgr_ram #(
        .DEPTH (FONT_WORDS),
        .WIDTH (16)
    ) u_default_font (
        .clk       (clk),
        .wr_en     (accept && (tcgr_pkg::func_t'(func) == tcgr_pkg::FUNC_WR_DEFAULT)),
        .wr_addr   (FONT_AW'(write_index)),
        .wr_data   (write_data),
        .rd_en     (render),
        .rd_addr_a (font_addr_hi),
        .rd_addr_b (font_addr_lo),
        .rd_data_a (def_hi),
        .rd_data_b (def_lo)
    );

    tcgr_ram #(
        .DEPTH (FONT_WORDS),
        .WIDTH (16)
    ) u_custom_font (
        .clk       (clk),
        .wr_en     (accept && (tcgr_pkg::func_t'(func) == tcgr_pkg::FUNC_WR_CUSTOM)),
        .wr_addr   (FONT_AW'(write_index)),
        .wr_data   (write_data),
        .rd_en     (render),
        .rd_addr_a (font_addr_hi),
        .rd_addr_b (font_addr_lo),
        .rd_data_a (cus_hi),
        .rd_data_b (cus_lo)
    );

    tcgr_ram #(
        .DEPTH (tcgr_pkg::PALETTE_SIZE),
        .WIDTH (12)
    ) u_palette (
        .clk       (clk),
        .wr_en     (accept && (tcgr_pkg::func_t'(func) == tcgr_pkg::FUNC_WR_PALETTE)),
        .wr_addr   (write_index[PAL_AW-1:0]),
        .wr_data   (write_data[11:0]),
        .rd_en     (render),
        .rd_addr_a (cell_word[15:12]),
        .rd_addr_b (cell_word[11:8]),
        .rd_data_a (pal_fg),
        .rd_data_b (pal_bg)
    );

    always_comb
    begin
        req.col   = s1_col_reg;
        req.row   = s1_row_reg;
        req.fg    = palette_source_reg ? pal_fg : tcgr_pkg::fixed_color(s1_fg_idx_reg);
        req.bg    = palette_source_reg ? pal_bg : tcgr_pkg::fixed_color(s1_bg_idx_reg);
        // blink off phase: no glyph bits, background only
        req.glyph = !s1_show_reg ? 32'd0 :
                    font_source_reg ? {cus_hi, cus_lo} : {def_hi, def_lo};
    end

    tcgr_serializer u_serializer (
        .clk           (clk),
        .rst_n         (rst_n),
        .load_valid    (s1_valid_reg),
        .req           (req),
        .load_ready    (load_ready),
        .pixel_valid   (pixel_valid),
        .pixel_stall   (pixel_stall),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .is_foreground (is_foreground),
        .last          (last)
    );

endmodule

// ===== rtl/core/tcgr_checker.sv =====
// Port-level checks for the text cell glyph renderer, bound to the top level.
module tcgr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       pixel_valid,
    input logic       pixel_stall,
    input logic [6:0] pixel_x,
    input logic [6:0] pixel_y,
    input logic       last
);

    logic pix_xfer;
    assign pix_xfer = pixel_valid && !pixel_stall;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_stall |=> pixel_valid && $stable(pixel_x) && $stable(pixel_y))
        else $error("pixel payload changed while stalled");

    a_cell_burst: assert property (@(posedge clk) disable iff (!rst_n)
        pix_xfer && !last |=> pixel_valid && (pixel_x[6:2] == $past(pixel_x[6:2]))
                              && (pixel_y[6:3] == $past(pixel_y[6:3])))
        else $error("gap or cell change inside a pixel burst");

    a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
        pix_xfer && !last |=> (pixel_y[2:0] + 3'd1) == $past(pixel_y[2:0]))
        else $error("glyph rows not bottom to top");

    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && last |-> (pixel_x[1:0] == 2'b11) && (pixel_y[2:0] == 3'b000))
        else $error("last flag off the final glyph pixel");

endmodule

bind text_cell_glyph_renderer tcgr_checker u_tcgr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .last        (last)
);

// ===== test/text_cell_glyph_renderer_test.sv =====
// Testbench for text_cell_glyph_renderer: random cells and store writes, pixel stream checked.
`timescale 1ns / 100ps

module text_cell_glyph_renderer_test;

    typedef struct packed {
        logic [6:0] x;
        logic [6:0] y;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       fg;
        logic       last;
    } pixel_t;

    typedef struct packed {
        tcgr_pkg::func_t op;
        logic [15:0]     word;
        logic [4:0]      col;
        logic [3:0]      row;
        logic            blink;
        logic [7:0]      widx;
        logic [15:0]     wdata;
    } cell_item_t;

    // Glyph/palette shadow and the queue of pixels still owed by the block.
    class pixel_scoreboard;
        logic [11:0] palette_ram [16];
        logic [15:0] default_font [256];
        logic [15:0] custom_font [256];
        bit          custom_palette;
        bit          custom_glyphs;
        pixel_t      pending [$];
        int          errors;

        function void fail(string msg);
            errors++;
            if (errors <= 10)
                $display("ERROR at %0t: %s", $realtime, msg);
        endfunction

        function string describe(pixel_t p);
            return $sformatf("x=%0d y=%0d rgb=%02h/%02h/%02h fg=%0b last=%0b",
                             p.x, p.y, p.r, p.g, p.b, p.fg, p.last);
        endfunction

        function logic [11:0] color(logic [3:0] idx);
            if (custom_palette)
                return palette_ram[idx];
            case (idx)
                4'h0: return 12'h000;
                4'h1: return 12'h00A;
                4'h2: return 12'h0A0;
                4'h3: return 12'h0AA;
                4'h4: return 12'hA00;
                4'h5: return 12'hA0A;
                4'h6: return 12'hA50;
                4'h7: return 12'hAAA;
                4'h8: return 12'h555;
                4'h9: return 12'h55F;
                4'hA: return 12'h5F5;
                4'hB: return 12'h5FF;
                4'hC: return 12'hF55;
                4'hD: return 12'hF5F;
                4'hE: return 12'hFF5;
                default: return 12'hFFF;
            endcase
        endfunction

        function logic [15:0] glyph_word(logic [7:0] idx);
            return custom_glyphs ? custom_font[idx] : default_font[idx];
        endfunction

        function void note_cell(cell_item_t it);
            logic [11:0] fgc;
            logic [11:0] bgc;
            logic [11:0] c;
            logic [31:0] glyph;
            logic        show;
            logic        on;
            pixel_t      p;
            int          k;
            case (it.op)
                tcgr_pkg::FUNC_WR_PALETTE: palette_ram[it.widx[3:0]] = it.wdata[11:0];
                tcgr_pkg::FUNC_WR_DEFAULT: default_font[it.widx] = it.wdata;
                tcgr_pkg::FUNC_WR_CUSTOM:  custom_font[it.widx] = it.wdata;
                default:
                begin
                    fgc = color(it.word[15:12]);
                    bgc = color(it.word[11:8]);
                    show = !it.word[7] || it.blink;
                    glyph = {glyph_word({it.word[6:0], 1'b0}),
                             glyph_word({it.word[6:0], 1'b1})};
                    // columns left to right, each column bottom row first
                    for (k = 0; k < tcgr_pkg::PIXELS; k++)
                    begin
                        on = glyph[tcgr_pkg::PIXELS - 1 - k] & show;
                        c = on ? fgc : bgc;
                        p.x = {it.col, 2'b00} + 7'(k / tcgr_pkg::GLYPH_HEIGHT);
                        p.y = {it.row, 3'b000} +
                              7'(tcgr_pkg::GLYPH_HEIGHT - 1 - k % tcgr_pkg::GLYPH_HEIGHT);
                        // nibble * 17 is the nibble repeated
                        p.r = {2{c[11:8]}};
                        p.g = {2{c[7:4]}};
                        p.b = {2{c[3:0]}};
                        p.fg = on;
                        p.last = (k == tcgr_pkg::PIXELS - 1);
                        pending.push_back(p);
                    end
                end
            endcase
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t want;
            if (pending.size() == 0)
            begin
                fail({"pixel with nothing pending: ", describe(got)});
                return;
            end
            want = pending.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.r !== want.r ||
                got.g !== want.g || got.b !== want.b || got.fg !== want.fg ||
                got.last !== want.last)
                fail({"pixel mismatch: expected ", describe(want), ", got ", describe(got)});
        endfunction
    endclass

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            psel = 1'b0;
    logic            penable = 1'b0;
    logic            pwrite = 1'b0;
    logic [2:0]      paddr = 3'd0;
    logic [31:0]     pwdata = 32'd0;
    logic [31:0]     prdata;
    logic            pready;
    logic            cell_valid = 1'b0;
    logic            cell_stall;
    tcgr_pkg::func_t func = tcgr_pkg::FUNC_RENDER;
    logic [15:0]     cell_word = 16'd0;
    logic [4:0]      cell_col = 5'd0;
    logic [3:0]      cell_row = 4'd0;
    logic            blink_on = 1'b0;
    logic [7:0]      write_index = 8'd0;
    logic [15:0]     write_data = 16'd0;
    logic            pixel_valid;
    logic            pixel_stall = 1'b0;
    logic [6:0]      pixel_x;
    logic [6:0]      pixel_y;
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
    logic            is_foreground;
    logic            last;

    pixel_scoreboard sb;

    // what the stimulus side knows has been loaded, so no unwritten entry is ever rendered
    bit def_written [256];
    bit cus_written [256];
    bit pal_written [16];
    bit gen_custom_palette;
    bit gen_custom_font;

    bit steady;       // no idling on either side
    bit hold_pixels;  // ask the pixel side for one long hold-off

    text_cell_glyph_renderer uut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && cell_valid && !cell_stall)
            sb.note_cell('{func, cell_word, cell_col, cell_row, blink_on,
                           write_index, write_data});
        if (rst_n && pixel_valid && !pixel_stall)
            sb.check_pixel({pixel_x, pixel_y, red, green, blue, is_foreground, last});
    end

    // pixel side stall pattern
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_pixels)
            begin
                hold_pixels = 1'b0;
                pixel_stall <= 1'b1;
                repeat (400) @(posedge clk);
            end
            else
                pixel_stall <= !steady && ($urandom_range(99) < 29);
        end
    end

    function automatic bit glyph_ready(logic [6:0] chr);
        if (gen_custom_font)
            return cus_written[{chr, 1'b0}] && cus_written[{chr, 1'b1}];
        return def_written[{chr, 1'b0}] && def_written[{chr, 1'b1}];
    endfunction

    function automatic cell_item_t cell_item(tcgr_pkg::func_t op, logic [15:0] word,
                                             logic [4:0] col, logic [3:0] row,
                                             logic blink, logic [7:0] widx,
                                             logic [15:0] wdata);
        return '{op, word, col, row, blink, widx, wdata};
    endfunction

    task automatic send_cell(input cell_item_t it);
        case (it.op)
            tcgr_pkg::FUNC_WR_PALETTE: pal_written[it.widx[3:0]] = 1'b1;
            tcgr_pkg::FUNC_WR_DEFAULT: def_written[it.widx] = 1'b1;
            tcgr_pkg::FUNC_WR_CUSTOM:  cus_written[it.widx] = 1'b1;
            default: ;
        endcase
        cell_valid <= 1'b1;
        func <= it.op;
        cell_word <= it.word;
        cell_col <= it.col;
        cell_row <= it.row;
        blink_on <= it.blink;
        write_index <= it.widx;
        write_data <= it.wdata;
        @(posedge clk);
        while (cell_stall)
            @(posedge clk);
        while (!steady && $urandom_range(99) < 29)
        begin
            cell_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic random_item(output cell_item_t it);
        int         pick;
        int         tries;
        logic [6:0] chr;
        logic [3:0] fgi;
        logic [3:0] bgi;
        pick = $urandom_range(99);
        it.word = 16'($urandom);
        it.col = 5'($urandom);
        it.row = 4'($urandom);
        it.blink = 1'($urandom);
        it.widx = 8'($urandom);
        it.wdata = 16'($urandom);
        if (pick < 24)
        begin
            if (pick < 8)
                it.op = tcgr_pkg::FUNC_WR_PALETTE;
            else if (pick < 16)
                it.op = tcgr_pkg::FUNC_WR_DEFAULT;
            else
                it.op = tcgr_pkg::FUNC_WR_CUSTOM;
            // keep the first few glyphs busy so renders see fresh content
            if (pick >= 8 && $urandom_range(1))
                it.widx = 8'($urandom_range(15));
        end
        else
        begin
            it.op = tcgr_pkg::FUNC_RENDER;
            chr = $urandom_range(1) ? 7'($urandom_range(7)) : 7'($urandom);
            for (tries = 0; tries < 16 && !glyph_ready(chr); tries++)
                chr = 7'($urandom);
            if (!glyph_ready(chr))
                chr = $urandom_range(1) ? 7'd127 : 7'd0;
            fgi = it.word[15:12];
            bgi = it.word[11:8];
            if (gen_custom_palette)
            begin
                for (tries = 0; tries < 16 && !pal_written[fgi]; tries++)
                    fgi = 4'($urandom);
                if (!pal_written[fgi])
                    fgi = 4'd15;
                for (tries = 0; tries < 16 && !pal_written[bgi]; tries++)
                    bgi = 4'($urandom);
                if (!pal_written[bgi])
                    bgi = 4'd0;
            end
            it.word = {fgi, bgi, it.word[7], chr};
        end
    endtask

    task automatic run_random(input int count);
        cell_item_t it;
        repeat (count)
        begin
            random_item(it);
            send_cell(it);
        end
    endtask

    // wait out every owed pixel, then let a trailing store write land
    task automatic settle();
        cell_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input tcgr_pkg::reg_index_t r, input bit v);
        logic [31:0] rd;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {r, 2'b00};
        pwdata <= {31'($urandom), v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rd = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (rd !== {31'd0, v})
            sb.fail($sformatf("register %s read back %h, expected %0d", r.name(), rd, v));
    endtask

    task automatic set_sources(input bit pal, input bit fnt);
        settle();
        write_reg(tcgr_pkg::REG_PALETTE_SOURCE, pal);
        write_reg(tcgr_pkg::REG_FONT_SOURCE, fnt);
        sb.custom_palette = pal;
        sb.custom_glyphs = fnt;
        gen_custom_palette = pal;
        gen_custom_font = fnt;
    endtask

    initial
    begin
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_sources(1'b0, 1'b0);
        // glyphs 0 and 127 in both banks, palette entries 0 and 15
        send_cell(cell_item(tcgr_pkg::FUNC_WR_DEFAULT,
                            16'h0000, 5'd0, 4'd0, 1'b0, 8'd0, 16'hFFFF));
        send_cell(cell_item(tcgr_pkg::FUNC_WR_DEFAULT,
                            16'hFFFF, 5'd31, 4'd15, 1'b1, 8'd1, 16'h0000));
        send_cell(cell_item(tcgr_pkg::FUNC_WR_DEFAULT,
                            16'h0000, 5'd0, 4'd0, 1'b0, 8'd254, 16'hA5A5));
        send_cell(cell_item(tcgr_pkg::FUNC_WR_DEFAULT,
                            16'h0000, 5'd0, 4'd0, 1'b0, 8'd255, 16'h5A5A));
        send_cell(cell_item(tcgr_pkg::FUNC_WR_CUSTOM,
                            16'h0000, 5'd0, 4'd0, 1'b0, 8'd0, 16'h8001));
        send_cell(cell_item(tcgr_pkg::FUNC_WR_CUSTOM,
                            16'h0000, 5'd0, 4'd0, 1'b0, 8'd1, 16'h7FFE));
        send_cell(cell_item(tcgr_pkg::FUNC_WR_CUSTOM,
                            16'h0000, 5'd0, 4'd0, 1'b0, 8'd254, 16'h0F0F));
        send_cell(cell_item(tcgr_pkg::FUNC_WR_CUSTOM,
                            16'h0000, 5'd0, 4'd0, 1'b0, 8'd255, 16'hF0F0));
        // palette index upper bits and data upper bits are dropped
        send_cell(cell_item(tcgr_pkg::FUNC_WR_PALETTE,
                            16'h0000, 5'd0, 4'd0, 1'b0, 8'hF0, 16'hFFFF));
        send_cell(cell_item(tcgr_pkg::FUNC_WR_PALETTE,
                            16'h0000, 5'd0, 4'd0, 1'b0, 8'h0F, 16'hF123));
        send_cell(cell_item(tcgr_pkg::FUNC_RENDER,
                            16'hF000, 5'd0, 4'd0, 1'b0, 8'd0, 16'h0000));
        // blinking cell in its off phase, highest column and row
        send_cell(cell_item(tcgr_pkg::FUNC_RENDER,
                            16'h0FFF, 5'd31, 4'd15, 1'b0, 8'd0, 16'h0000));
        send_cell(cell_item(tcgr_pkg::FUNC_RENDER,
                            16'h69FF, 5'd17, 4'd11, 1'b1, 8'd0, 16'h0000));
        send_cell(cell_item(tcgr_pkg::FUNC_RENDER,
                            16'hA500, 5'd5, 4'd12, 1'b1, 8'hFF, 16'hFFFF));
        run_random(40);

        set_sources(1'b1, 1'b1);
        steady = 1'b1;
        run_random(50);
        steady = 1'b0;

        set_sources(1'b1, 1'b0);
        hold_pixels = 1'b1;
        run_random(45);

        set_sources(1'b0, 1'b1);
        run_random(45);

        set_sources(1'b0, 1'b0);
        run_random(40);

        settle();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
